FILE: design/minmax_contrast_normalize_unit_defines.svh
// Assertion macros used by the top block to check itself.
`ifndef MINMAX_CONTRAST_NORMALIZE_UNIT_DEFINES_SVH
`define MINMAX_CONTRAST_NORMALIZE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and off during reset.
`define MCN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("minmax contrast normalize: same-cycle check failed");

// Next-cycle implication, sampled on clk and off during reset.
`define MCN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("minmax contrast normalize: next-cycle check failed");

`endif

FILE: design/mcn_pkg.sv
package mcn_pkg;

  localparam int PIX_W     = 8;
  localparam int MAG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HIGH = 2'd1;

  localparam logic CMD_MEASURE   = 1'b0;
  localparam logic CMD_NORMALIZE = 1'b1;

  // Operands captured when a normalize item is accepted.
  typedef struct packed {
    logic                    valid;
    logic                    flat;
    logic signed [PIX_W:0]   diff;
    logic signed [PIX_W:0]   scale;
    logic [PIX_W-1:0]        den;
    logic [PIX_W-1:0]        tl;
  } s0_t;

  // Word handed from one divider cell to the next.
  typedef struct packed {
    logic                    valid;
    logic                    neg;
    logic                    flat;
    logic [PIX_W-1:0]        tl;
    logic [PIX_W-1:0]        den;
    logic [PIX_W-1:0]        rem;
    logic [MAG_W-1:0]        dvd;
    logic [MAG_W-1:0]        quo;
  } tok_t;

endpackage

FILE: design/mcn_front.sv
module mcn_front import mcn_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_accept,
  input  logic                 command,
  input  logic [PIX_W-1:0]     pixel,
  input  logic                 frame_start,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PIX_W-1:0]     cfg_data,
  output s0_t                  s0_o,
  output logic [PIX_W-1:0]     min_o,
  output logic [PIX_W-1:0]     max_o
);

  logic [PIX_W-1:0] tl_r, th_r, min_r, max_r;
  logic             s0_valid_r;
  s0_t              s0_r;
  logic             flat;

  assign flat = (max_r <= min_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tl_r       <= '0;
      th_r       <= '1;
      min_r      <= '1;
      max_r      <= '0;
      s0_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TARGET_LOW:  tl_r <= cfg_data;
          CFG_TARGET_HIGH: th_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_accept && command == CMD_MEASURE) begin
        if (frame_start) begin
          min_r <= pixel;
          max_r <= pixel;
        end else begin
          if (pixel < min_r) min_r <= pixel;
          if (pixel > max_r) max_r <= pixel;
        end
      end
      if (en) s0_valid_r <= in_accept && command == CMD_NORMALIZE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r.valid <= 1'b0;
      s0_r.flat  <= flat;
      s0_r.diff  <= $signed({1'b0, pixel}) - $signed({1'b0, min_r});
      s0_r.scale <= $signed({1'b0, th_r}) - $signed({1'b0, tl_r});
      s0_r.den   <= flat ? PIX_W'(1) : max_r - min_r;
      s0_r.tl    <= tl_r;
    end
  end

  always_comb begin
    s0_o       = s0_r;
    s0_o.valid = s0_valid_r;
  end

  assign min_o = min_r;
  assign max_o = max_r;

endmodule

FILE: design/mcn_div_cell.sv
module mcn_div_cell import mcn_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  tok_t tok_i,
  output tok_t tok_o
);

  logic [PIX_W:0] trial;
  logic           fits;
  logic           valid_r;
  tok_t           tok_r;
  tok_t           tok_nxt;

  // One restoring step: bring down the next dividend bit.
  assign trial = {tok_i.rem, tok_i.dvd[MAG_W-1]};
  assign fits  = (trial >= {1'b0, tok_i.den});

  always_comb begin
    tok_nxt     = tok_i;
    tok_nxt.rem = fits ? PIX_W'(trial - {1'b0, tok_i.den}) : trial[PIX_W-1:0];
    tok_nxt.dvd = {tok_i.dvd[MAG_W-2:0], 1'b0};
    tok_nxt.quo = {tok_i.quo[MAG_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= tok_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tok_r <= tok_nxt;
    end
  end

  always_comb begin
    tok_o       = tok_r;
    tok_o.valid = valid_r;
  end

endmodule

FILE: design/minmax_contrast_normalize_unit.sv
// Channel  Direction  Handshake                Payload
// in       slave      in_tvalid / in_tready    in_tdata, in_tuser
// out      master     out_tvalid / out_tready  out_tdata, out_tuser
// cfg      slave      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One item is accepted per cycle while the output is not stalled; out_tvalid for a normalize
// item rises after it passes the capture register, which loads at the accepting edge, then one
// multiply stage, sixteen divider cells and the output register.
// Measure items update the statistics at once and leave a bubble in the divider chain.
// A stalled output freezes the whole chain, and in_tready falls with it.
// Reset is synchronous; no clearing pass is needed.
`include "minmax_contrast_normalize_unit_defines.svh"

module minmax_contrast_normalize_unit import mcn_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] pixel_in
  input  logic [1:0]           in_tuser,   // [0] command, [1] frame_start
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [7:0] pixel_out
  output logic [0:0]           out_tuser,  // [0] flat_frame
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int NCELL = MAG_W;

  logic                   en;
  logic                   in_accept;
  s0_t                    s0;
  logic [PIX_W-1:0]       run_min, run_max;
  logic signed [17:0]     prod;
  logic signed [17:0]     prod_abs;
  logic                   t1_valid_r;
  tok_t                   t1_r;
  tok_t                   chain_head;
  tok_t                   chain [0:NCELL];
  tok_t                   last;
  logic [MAG_W:0]         q_ceil;
  logic signed [17:0]     q_s;
  logic signed [17:0]     sum;
  logic [PIX_W-1:0]       pix_res;
  logic                   out_valid_r;
  logic [PIX_W-1:0]       out_pix_r;
  logic                   out_flat_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign in_accept = in_tvalid && en;
  assign cfg_ready = 1'b1;

  mcn_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_accept   (in_accept),
    .command     (in_tuser[0]),
    .pixel       (in_tdata),
    .frame_start (in_tuser[1]),
    .cfg_we      (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s0_o        (s0),
    .min_o       (run_min),
    .max_o       (run_max)
  );

  assign prod     = s0.diff * s0.scale;
  assign prod_abs = (prod < 0) ? -prod : prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_valid_r <= 1'b0;
    end else if (en) begin
      t1_valid_r <= s0.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r.valid <= 1'b0;
      t1_r.neg   <= (prod < 0);
      t1_r.flat  <= s0.flat;
      t1_r.tl    <= s0.tl;
      t1_r.den   <= s0.den;
      t1_r.rem   <= '0;
      t1_r.dvd   <= prod_abs[MAG_W-1:0];
      t1_r.quo   <= '0;
    end
  end

  always_comb begin
    chain_head       = t1_r;
    chain_head.valid = t1_valid_r;
  end

  assign chain[0] = chain_head;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    mcn_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .tok_i (chain[i]),
      .tok_o (chain[i+1])
    );
  end

  assign last = chain[NCELL];

  // Ceiling of a positive quotient rounds up on a remainder; a negative one
  // is the negated floor of the magnitude.
  assign q_ceil = {1'b0, last.quo} + (MAG_W+1)'(!last.neg && last.rem != '0);
  assign q_s    = $signed({1'b0, q_ceil});
  assign sum    = $signed({10'd0, last.tl}) + (last.neg ? -q_s : q_s);

  always_comb begin
    if (sum < 0) begin
      pix_res = '0;
    end else if (sum > 18'sd255) begin
      pix_res = '1;
    end else begin
      pix_res = sum[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pix_r  <= last.flat ? last.tl : pix_res;
      out_flat_r <= last.flat;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_pix_r;
  assign out_tuser[0] = out_flat_r;

  `MCN_ASSERT_IMP(a_stall_only_on_full_out, !in_tready, out_valid_r && !out_tready)
  `MCN_ASSERT_IMP(a_chain_rem_below_den, last.valid, last.rem < last.den)
  `MCN_ASSERT_NXT(a_frame_restart_flat,
    in_accept && in_tuser[0] == CMD_MEASURE && in_tuser[1], run_min == run_max)

endmodule
